// File: rtl/interval_timing_statistics_defines.svh
// Assertion macros shared by the interval timing statistics RTL.
// No dependencies; include with the bare file name.
`ifndef INTERVAL_TIMING_STATISTICS_DEFINES_SVH
`define INTERVAL_TIMING_STATISTICS_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define ITS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ITS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/its_pkg.sv
// Package for interval timing statistics: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package its_pkg;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [29:0] NS_MAX     = 30'd999999999;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_READ  = 2'd2,
		OP_READ3 = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_START_BUSY = 2'd1,
		ST_STOP_IDLE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEL_LAST = 2'd0,
		SEL_MIN  = 2'd1,
		SEL_MAX  = 2'd2,
		SEL_MEAN = 2'd3
	} stat_sel_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  id;
		logic [1:0]  stat_select;
		logic [31:0] now_sec;
		logic [29:0] now_nsec;
		logic [63:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        measuring;
		logic [31:0] count;
		logic [31:0] stat_sec;
		logic [29:0] stat_nsec;
		logic [63:0] stat_ticks;
	} out_item_t;

	typedef struct packed {
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [63:0] ticks;
	} stamp_t;

	// One record as held in memory.
	typedef struct packed {
		logic        running;
		logic [31:0] count;
		stamp_t      start;
		stamp_t      last;
		stamp_t      min;
		stamp_t      max;
		stamp_t      mean;
	} record_t;

	localparam int REC_W = $bits(record_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_WRITE,
		S_OUT
	} state_t;

	// Handshake between sequencer and divider.
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// a < b on (sec, nsec)
	function automatic logic stamp_lt(stamp_t a, stamp_t b);
		return (a.sec < b.sec) || ((a.sec == b.sec) && (a.nsec < b.nsec));
	endfunction

endpackage

// File: rtl/interval_timing_statistics.sv
// Top level of the interval timing statistics block.
// Uses its_pkg, its_ram, its_div and interval_timing_statistics_defines.svh.
`timescale 1ns / 1ps
// Per-ID interval profiler. Records live in one RAM, NUM_IDS entries rounded
// up to a power of two, that is cleared after reset by a pass over NUM_IDS
// entries, during which no transaction is taken. Start, read and failed stop
// go through read, execute, write-back and output states before out_valid
// rises. A successful stop adds a state that finishes the 64-bit tick
// product and starts the divider, then the bit-serial divider forming the
// running mean (one quotient bit per cycle) until its done flag. One event
// is in flight at a time; the input reopens once the result is loaded into
// the output register, and a result still waiting there holds that load.
module interval_timing_statistics #(
	parameter int NUM_IDS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  its_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output its_pkg::out_item_t  out_data
);
	import its_pkg::*;
	`include "interval_timing_statistics_defines.svh"

	localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

	state_t      state_q, state_d;
	in_item_t    cmd_q;
	in_item_t    cmd_in;
	logic [AW-1:0] addr_q;
	logic [AW:0] clr_q;
	record_t     rec_rd, rec_q, rec_w;
	logic        we;
	logic [AW-1:0] ram_addr;
	status_t     status_q;
	logic        mean_go;
	logic [95:0] ms_q, mn_q;
	logic [63:0] pt_lo_q, dt_q, mt;
	logic [31:0] pt_hi_q;
	logic [31:0] n_q;
	div_req_t    dreq;
	div_stat_t   dstat;
	logic [31:0] q_sec;
	logic [29:0] q_nsec;
	logic [63:0] q_ticks;
	out_item_t   out_q;
	logic        out_v_q;
	stamp_t      now, d, sel;
	logic [29:0] nclamp;
	logic [AW-1:0] id_tab [16];
	logic [AW-1:0] id_mod;
	logic [31:0] ds;
	logic [30:0] dn_raw;
	logic [29:0] dn;
	logic        borrow;

	its_ram #(.WIDTH(REC_W), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(rec_w), .rdata(rec_rd)
	);

	its_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.num_sec(ms_q), .num_nsec(mn_q), .num_ticks(mt), .den(n_q),
		.stat(dstat), .q_sec(q_sec), .q_nsec(q_nsec), .q_ticks(q_ticks)
	);

	// id folding table, constant per NUM_IDS
	always_comb begin
		for (int k = 0; k < 16; k++) id_tab[k] = AW'(k % NUM_IDS);
		nclamp = (in_data.now_nsec > NS_MAX) ? NS_MAX : in_data.now_nsec;
		id_mod = id_tab[in_data.id];
		cmd_in = in_data;
		cmd_in.now_nsec = nclamp;
	end

	// interval from the record read back
	always_comb begin
		now.sec   = cmd_q.now_sec;
		now.nsec  = cmd_q.now_nsec;
		now.ticks = cmd_q.now_ticks;
		borrow    = now.nsec < rec_q.start.nsec;
		dn_raw    = {1'b0, now.nsec} - {1'b0, rec_q.start.nsec}
			+ (borrow ? {1'b0, NS_PER_SEC} : 31'd0);
		dn        = dn_raw[29:0];
		ds        = now.sec - rec_q.start.sec - {31'd0, borrow};
		d.sec     = ds;
		d.nsec    = dn;
		d.ticks   = now.ticks - rec_q.start.ticks;
		mean_go   = (cmd_q.opcode == OP_STOP) && rec_q.running;
		// mean.ticks*(n-1)+d.ticks mod 2^64 from two 32-bit partial products
		mt        = pt_lo_q + {pt_hi_q, 32'd0} + dt_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == (AW + 1)'(NUM_IDS - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_READ;
			S_READ:  state_d = S_EXEC;
			S_EXEC:  state_d = mean_go ? S_MUL : S_WRITE;
			S_MUL:   state_d = S_DIV;
			S_DIV:   if (dstat.done) state_d = S_WRITE;
			S_WRITE: state_d = S_OUT;
			S_OUT:   if (!out_v_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		dreq.start = (state_q == S_MUL);
		we = (state_q == S_CLEAR) || (state_q == S_WRITE);
		ram_addr = (state_q == S_CLEAR) ? clr_q[AW-1:0]
			: (state_q == S_IDLE) ? id_mod : addr_q;
		rec_w = (state_q == S_CLEAR) ? '0 : rec_q;
		case (cmd_q.stat_select)
			SEL_LAST: sel = rec_q.last;
			SEL_MIN:  sel = rec_q.min;
			SEL_MAX:  sel = rec_q.max;
			default:  sel = rec_q.mean;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_OUT && (!out_v_q || out_ready)) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= cmd_in;
			addr_q <= id_mod;
		end
		case (state_q)
			S_READ: begin
				rec_q    <= rec_rd;
				status_q <= ST_OK;
			end
			S_EXEC: begin
				if (cmd_q.opcode == OP_START) begin
					if (rec_q.running) begin
						status_q <= ST_START_BUSY;
					end else begin
						rec_q.running <= 1'b1;
						if (rec_q.count != '1) rec_q.count <= rec_q.count + 32'd1;
						rec_q.start <= now;
					end
				end else if (cmd_q.opcode == OP_STOP) begin
					if (!rec_q.running) begin
						status_q <= ST_STOP_IDLE;
					end else begin
						rec_q.running <= 1'b0;
						rec_q.last <= d;
						if (rec_q.count == 32'd1 || stamp_lt(d, rec_q.min))
							rec_q.min <= d;
						if (stamp_lt(rec_q.max, d)) rec_q.max <= d;
					end
				end
				// mean*(n-1)+d, formed ahead of the divider
				n_q  <= (rec_q.count == '0) ? 32'd1 : rec_q.count;
				ms_q <= 96'(64'(rec_q.mean.sec) * 64'(rec_q.count - 32'd1)
					+ 64'(d.sec));
				mn_q <= 96'(64'(rec_q.mean.nsec) * 64'(rec_q.count - 32'd1)
					+ 64'(d.nsec));
				pt_lo_q <= 64'(rec_q.mean.ticks[31:0]) * 64'(rec_q.count - 32'd1);
				pt_hi_q <= rec_q.mean.ticks[63:32] * (rec_q.count - 32'd1);
				dt_q    <= d.ticks;
			end
			S_DIV: if (dstat.done) begin
				rec_q.mean.sec   <= q_sec;
				rec_q.mean.nsec  <= q_nsec;
				rec_q.mean.ticks <= q_ticks;
			end
			S_OUT: if (!out_v_q || out_ready) begin
				out_q.status     <= status_q;
				out_q.measuring  <= rec_q.running;
				out_q.count      <= rec_q.count;
				out_q.stat_sec   <= sel.sec;
				out_q.stat_nsec  <= sel.nsec;
				out_q.stat_ticks <= sel.ticks;
			end
			default: ;
		endcase
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	`ITS_ASSERT_IMP(a_no_accept_clear, clk, arst_n, state_q == S_CLEAR, !in_ready)
	`ITS_ASSERT_IMP(a_div_only_stop, clk, arst_n, dreq.start, cmd_q.opcode == OP_STOP)
	`ITS_ASSERT_NXT(a_out_after_done, clk, arst_n,
		state_q == S_OUT && (!out_v_q || out_ready), out_valid)
	`ITS_ASSERT_IMP(a_div_idle_outside, clk, arst_n, dstat.busy,
		state_q == S_DIV)
endmodule

// File: rtl/its_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module its_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: rtl/its_div.sv
// Restoring divider: three dividends (96, 64, 96 bits) over one 32-bit divisor.
// Uses its_pkg; one quotient bit per dividend per cycle; ticks stop at 64 bits.
`timescale 1ns / 1ps
module its_div (
	input  logic              clk,
	input  logic              arst_n,
	input  its_pkg::div_req_t req,
	input  logic [95:0]       num_sec,
	input  logic [95:0]       num_nsec,
	input  logic [63:0]       num_ticks,
	input  logic [31:0]       den,
	output its_pkg::div_stat_t stat,
	output logic [31:0]       q_sec,
	output logic [29:0]       q_nsec,
	output logic [63:0]       q_ticks
);
	import its_pkg::*;

	logic [95:0] ns_q, nn_q, qs_q, qn_q;
	logic [63:0] nt_q, qt_q;
	logic [32:0] rs_q, rn_q, rt_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] ts, tn, tt;
	logic        ks, kn, kt;

	always_comb begin
		ts = {rs_q[31:0], ns_q[95]};
		tn = {rn_q[31:0], nn_q[95]};
		tt = {rt_q[31:0], nt_q[63]};
		ks = ts >= {1'b0, den_q};
		kn = tn >= {1'b0, den_q};
		kt = (cnt_q < 7'd64) && (tt >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd95) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ns_q  <= num_sec;
			nn_q  <= num_nsec;
			nt_q  <= num_ticks;
			den_q <= den;
			rs_q  <= '0;
			rn_q  <= '0;
			rt_q  <= '0;
			qs_q  <= '0;
			qn_q  <= '0;
			qt_q  <= '0;
		end else if (busy_q) begin
			ns_q <= {ns_q[94:0], 1'b0};
			nn_q <= {nn_q[94:0], 1'b0};
			qs_q <= {qs_q[94:0], ks};
			qn_q <= {qn_q[94:0], kn};
			rs_q <= ks ? ts - {1'b0, den_q} : ts;
			rn_q <= kn ? tn - {1'b0, den_q} : tn;
			// ticks shift only while cnt_q is below 64
			if (cnt_q < 7'd64) begin
				nt_q <= {nt_q[62:0], 1'b0};
				qt_q <= {qt_q[62:0], kt};
				rt_q <= kt ? tt - {1'b0, den_q} : tt;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign q_sec     = qs_q[31:0];
	assign q_nsec    = qn_q[29:0];
	assign q_ticks   = qt_q;
endmodule

// File: test/testbench.sv
// Testbench for interval_timing_statistics: random and directed start, stop and read
// transactions checked against a built-in per-ID statistics predictor.
// Depends on its_pkg and the interval_timing_statistics RTL.
`timescale 1ns / 1ps

class stats_scoreboard;
	its_pkg::out_item_t pending[$];
	int errors;
	logic        run_flag[16];
	logic [31:0] starts[16];
	its_pkg::stamp_t t0[16], last_iv[16], min_iv[16], max_iv[16], mean_iv[16];

	function new();
		errors = 0;
		for (int i = 0; i < 16; i++) begin
			run_flag[i] = 0; starts[i] = 0;
			t0[i] = '0; last_iv[i] = '0; min_iv[i] = '0; max_iv[i] = '0; mean_iv[i] = '0;
		end
	endfunction

	function bit earlier(its_pkg::stamp_t a, its_pkg::stamp_t b);
		return (a.sec < b.sec) || (a.sec == b.sec && a.nsec < b.nsec);
	endfunction

	// predict the result of one accepted transaction
	function void note_input(its_pkg::in_item_t it);
		int k;
		its_pkg::stamp_t now, d, s;
		its_pkg::out_item_t r;
		logic [63:0] n;
		logic [95:0] acc;
		k = it.id;
		now.sec = it.now_sec;
		now.nsec = (it.now_nsec > its_pkg::NS_MAX) ? its_pkg::NS_MAX : it.now_nsec;
		now.ticks = it.now_ticks;
		r = '0;
		r.status = its_pkg::ST_OK;
		if (it.opcode == its_pkg::OP_START) begin
			if (run_flag[k]) r.status = its_pkg::ST_START_BUSY;
			else begin
				run_flag[k] = 1;
				if (starts[k] != 32'hFFFF_FFFF) starts[k]++;
				t0[k] = now;
			end
		end else if (it.opcode == its_pkg::OP_STOP) begin
			if (!run_flag[k]) r.status = its_pkg::ST_STOP_IDLE;
			else begin
				d.sec = now.sec - t0[k].sec;
				if (now.nsec >= t0[k].nsec) d.nsec = now.nsec - t0[k].nsec;
				else begin
					d.nsec = now.nsec + its_pkg::NS_PER_SEC - t0[k].nsec;
					d.sec = d.sec - 32'd1;
				end
				d.ticks = now.ticks - t0[k].ticks;
				run_flag[k] = 0;
				last_iv[k] = d;
				if (starts[k] == 1 || earlier(d, min_iv[k])) min_iv[k] = d;
				if (earlier(max_iv[k], d)) max_iv[k] = d;
				n = (starts[k] == 0) ? 64'd1 : {32'd0, starts[k]};
				acc = {64'd0, mean_iv[k].sec} * (n - 1) + d.sec;
				mean_iv[k].sec = 32'(acc / n);
				acc = {66'd0, mean_iv[k].nsec} * (n - 1) + d.nsec;
				mean_iv[k].nsec = 30'(acc / n);
				mean_iv[k].ticks = (mean_iv[k].ticks * (n - 1) + d.ticks) / n;
			end
		end
		case (it.stat_select)
			its_pkg::SEL_LAST: s = last_iv[k];
			its_pkg::SEL_MIN:  s = min_iv[k];
			its_pkg::SEL_MAX:  s = max_iv[k];
			default:           s = mean_iv[k];
		endcase
		r.measuring = run_flag[k];
		r.count = starts[k];
		r.stat_sec = s.sec;
		r.stat_nsec = s.nsec;
		r.stat_ticks = s.ticks;
		pending.push_back(r);
	endfunction

	function void check_result(its_pkg::out_item_t got);
		its_pkg::out_item_t e;
		if (pending.size() == 0) begin
			$error("result with no expectation waiting");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.status !== e.status) begin
			$error("status exp %0d got %0d", e.status, got.status); errors++;
		end
		if (got.measuring !== e.measuring) begin
			$error("measuring exp %0d got %0d", e.measuring, got.measuring); errors++;
		end
		if (got.count !== e.count) begin
			$error("count exp %0d got %0d", e.count, got.count); errors++;
		end
		if (got.stat_sec !== e.stat_sec) begin
			$error("stat_sec exp %0d got %0d", e.stat_sec, got.stat_sec); errors++;
		end
		if (got.stat_nsec !== e.stat_nsec) begin
			$error("stat_nsec exp %0d got %0d", e.stat_nsec, got.stat_nsec); errors++;
		end
		if (got.stat_ticks !== e.stat_ticks) begin
			$error("stat_ticks exp %0d got %0d", e.stat_ticks, got.stat_ticks); errors++;
		end
	endfunction
endclass

module testbench;
	import its_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;

	stats_scoreboard board = new();
	bit calm = 0;
	int n_start = 0, n_stop = 0, n_read = 0;
	logic [31:0] clk_sec = 0;
	logic [63:0] clk_ticks = 0;

	interval_timing_statistics #(.NUM_IDS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) board.check_result(out_data);
		out_ready <= calm || ($urandom_range(99) >= 37);
	end

	// valid stays up after acceptance until the next item or an idle cycle
	task automatic send(input in_item_t it);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(it);
		case (it.opcode)
			OP_START: n_start++;
			OP_STOP:  n_stop++;
			default:  n_read++;
		endcase
	endtask

	function automatic in_item_t make(opcode_t op, int id, int sel, logic [31:0] s,
			logic [29:0] ns, logic [63:0] t);
		in_item_t it;
		it.opcode = op; it.id = 4'(id); it.stat_select = 2'(sel);
		it.now_sec = s; it.now_nsec = ns; it.now_ticks = t;
		return it;
	endfunction

	// mostly monotonic time with random jumps, occasionally wild values
	function automatic in_item_t rand_item(opcode_t op);
		logic [29:0] ns;
		if ($urandom_range(9) == 0) begin
			ns = 30'($urandom);
			return make(op, $urandom_range(15), $urandom_range(3), $urandom,
				ns, {$urandom, $urandom});
		end
		clk_sec += $urandom_range(3);
		clk_ticks += $urandom_range(1 << 20);
		ns = 30'($urandom_range(999999999));
		return make(op, $urandom_range(15), $urandom_range(3), clk_sec, ns, clk_ticks);
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);
		// directed: extremes, errors, nsec borrow and clamp, wrap, all selects
		send(make(OP_STOP, 0, SEL_LAST, 0, 0, 0));
		send(make(OP_START, 15, SEL_MIN, 32'hFFFF_FFFF, 30'h3FFF_FFFF, '1));
		send(make(OP_START, 15, SEL_MAX, 1, 2, 3));
		send(make(OP_STOP, 15, SEL_LAST, 5, 0, 64'd10));
		send(make(OP_START, 15, SEL_MEAN, 0, 999999999, 64'd0));
		send(make(OP_STOP, 15, SEL_MEAN, 0, 0, '1));
		for (int s = 0; s < 4; s++) send(make(OP_READ, 15, s, 0, 0, 0));
		send(make(OP_READ3, 15, SEL_MIN, '1, '1, '1));
		send(make(OP_START, 7, SEL_LAST, 100, 500, 64'd1000));
		send(make(OP_STOP, 7, SEL_MIN, 100, 500, 64'd1000));
		send(make(OP_START, 7, SEL_LAST, 0, 0, 0));
		send(make(OP_STOP, 7, SEL_MAX, 32'hFFFF_FFFF, 999999999, '1));
		send(make(OP_READ, 7, SEL_MEAN, 0, 0, 0));
		for (int i = 0; i < 1840; i++) begin
			calm = (i >= 600 && i < 800);
			if ($urandom_range(9) < 8) begin
				int id;
				in_item_t it;
				it = rand_item(OP_START);
				id = it.id;
				send(it);
				it = rand_item($urandom_range(4) == 0 ? OP_READ : OP_STOP);
				it.id = 4'(id);
				send(it);
				i++;
			end else begin
				send(rand_item(opcode_t'($urandom_range(3))));
			end
		end
		in_valid <= 0;
		calm = 1;
		fork
			begin
				while (board.pending.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
			end
			begin
				repeat (50000) @(posedge clk);
				$display("pending results never arrived");
			end
		join_any
		$display("Covered %0d starts, %0d stops, %0d reads/other over 16 records.",
			n_start, n_stop, n_read);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
